// ----- design/lppc_pkg.sv -----
`timescale 1ns / 1ps

package lppc_pkg;

	localparam int PIX_W              = 8;
	localparam int RES_W              = 11;
	localparam int COEF_W             = 16;
	localparam int FW_W               = 11;
	localparam int FH_W               = 16;
	localparam int CFG_DATA_W         = 16;
	localparam int CFG_IDX_W          = 3;
	localparam int SUM_W              = 28;
	localparam int DEF_MAX_WIDTH      = 1024;
	localparam int DEF_COEF_FRAC_BITS = 12;

	localparam logic [PIX_W-1:0]         EDGE_VALUE    = 8'd128;
	localparam logic signed [COEF_W-1:0] COEF_LEFT_RST = 16'sd4096;
	localparam logic signed [COEF_W-1:0] COEF_ZERO_RST = 16'sd0;
	localparam logic [FW_W-1:0]          FW_RST        = 11'd1024;
	localparam logic [FH_W-1:0]          FH_RST        = 16'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DECODE_MODE  = 3'd0,
		REG_COEF_LEFT    = 3'd1,
		REG_COEF_UP      = 3'd2,
		REG_COEF_UPLEFT  = 3'd3,
		REG_FRAME_WIDTH  = 3'd4,
		REG_FRAME_HEIGHT = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic                     decode_mode;
		logic signed [COEF_W-1:0] coef_left;
		logic signed [COEF_W-1:0] coef_up;
		logic signed [COEF_W-1:0] coef_upleft;
		logic [FW_W-1:0]          frame_width;
		logic [FH_W-1:0]          frame_height;
	} cfg_t;

	typedef struct packed {
		logic col_nz;
		logic row_nz;
		logic last;
		logic same_prev;
	} pos_t;

endpackage

// ----- design/lppc_if.sv -----
`timescale 1ns / 1ps

interface lppc_in_if;
	import lppc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [PIX_W-1:0]        pixel_in;
	logic signed [RES_W-1:0] residual_in;

	modport source (output valid, pixel_in, residual_in, input ready);
	modport sink (input valid, pixel_in, residual_in, output ready);
endinterface

interface lppc_out_if;
	import lppc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [RES_W-1:0] residual_out;
	logic [PIX_W-1:0]        pixel_out;
	logic                    range_flag;
	logic                    frame_end;

	modport source (output valid, residual_out, pixel_out, range_flag, frame_end, input ready);
	modport sink (input valid, residual_out, pixel_out, range_flag, frame_end, output ready);
endinterface

// ----- design/lossless_predictive_pixel_codec.sv -----
`timescale 1ns / 1ps

// Channel   Kind     Fields
// sample    sink     pixel_in[7:0], residual_in[10:0] signed
// result    source   residual_out[10:0] signed, pixel_out[7:0], range_flag, frame_end
// cfg       write    cfg_write, cfg_index[2:0], cfg_data[15:0]
//
// One item per clock is sustained while result.ready holds; each item reaches the output
// register through line buffer read, partial products, final predict and clamp.
// The final stage closes the left-neighbour loop with one 8x17 multiply-add per cycle.
// Reset clears the pipeline and the position and sets left/up-left to the edge value;
// the line buffer is not cleared. Stalled output fills bubbles before sample.ready drops.

module lossless_predictive_pixel_codec #(
	parameter int MAX_WIDTH      = lppc_pkg::DEF_MAX_WIDTH,
	parameter int COEF_FRAC_BITS = lppc_pkg::DEF_COEF_FRAC_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	lppc_in_if.sink                         sample,
	lppc_out_if.source                      result,
	input  logic                            cfg_write,
	input  logic [lppc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lppc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lppc_pkg::*;

	localparam int AW      = $clog2(MAX_WIDTH);
	localparam int VW      = SUM_W + 1;
	localparam int RES_MIN = -(1 << (RES_W - 1));
	localparam int RES_MAX = (1 << (RES_W - 1)) - 1;
	localparam int PIX_MAX = (1 << PIX_W) - 1;

	function automatic logic signed [SUM_W-1:0] mul_pix(input logic [PIX_W-1:0] p,
		input logic signed [COEF_W:0] c);
		mul_pix = SUM_W'($signed({1'b0, p})) * SUM_W'(c);
	endfunction

	cfg_t          cfg;
	pos_t          pos_new;
	logic [AW-1:0] addr_new;

	logic accept;
	logic mv1;
	logic mv2;
	logic mv3;

	logic                    s1_v;
	pos_t                    pos_s1;
	logic [AW-1:0]           addr_s1;
	logic                    mode_s1;
	logic [PIX_W-1:0]        pix_s1;
	logic signed [RES_W-1:0] res_s1;
	logic                    fwd_v_q;
	logic [PIX_W-1:0]        fwd_d_q;
	logic [PIX_W-1:0]        ram_rdata;
	logic [PIX_W-1:0]        up_s1;

	logic                    s2_v;
	pos_t                    pos_s2;
	logic [AW-1:0]           addr_s2;
	logic                    mode_s2;
	logic [PIX_W-1:0]        pix_s2;
	logic signed [RES_W-1:0] res_s2;
	logic [PIX_W-1:0]        up_s2;

	logic                    s3_v;
	pos_t                    pos_s3;
	logic [AW-1:0]           addr_s3;
	logic                    mode_s3;
	logic [PIX_W-1:0]        pix_s3;
	logic signed [RES_W-1:0] res_s3;
	logic [PIX_W-1:0]        up_s3;
	logic signed [SUM_W-1:0] part_s3;
	logic signed [COEF_W:0]  cf_s3;

	logic [PIX_W-1:0] left_q;
	logic [PIX_W-1:0] ul_q;

	logic                    out_v_q;
	logic signed [RES_W-1:0] out_res_q;
	logic [PIX_W-1:0]        out_pix_q;
	logic                    out_flag_q;
	logic                    out_end_q;

	logic hit_new;
	logic hit_s1;

	logic signed [COEF_W:0]  cl;
	logic signed [COEF_W:0]  cu;
	logic signed [COEF_W:0]  cul;
	logic [PIX_W-1:0]        ul_src;
	logic signed [COEF_W:0]  cf_l;
	logic signed [COEF_W:0]  cf_u;
	logic signed [COEF_W:0]  cf_c;
	logic signed [SUM_W-1:0] term_l;
	logic signed [SUM_W-1:0] term_u;
	logic signed [SUM_W-1:0] term_ul;
	logic signed [SUM_W-1:0] part_c;

	logic [PIX_W-1:0]        up_res;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] adj;
	logic signed [SUM_W-1:0] pred;
	logic signed [VW-1:0]    enc;
	logic signed [VW-1:0]    dec;
	logic [PIX_W-1:0]        kept;
	logic signed [RES_W-1:0] res_val;
	logic                    flag;

	lppc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lppc_pos #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cfg    (cfg),
		.addr   (addr_new),
		.pos    (pos_new)
	);

	lppc_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_row (
		.clk     (clk),
		.wr_en   (mv3),
		.wr_addr (addr_s3),
		.wr_data (kept),
		.rd_en   (accept),
		.rd_addr (addr_new),
		.rd_data (ram_rdata)
	);

	assign mv3          = s3_v && (!out_v_q || result.ready);
	assign mv2          = s2_v && (!s3_v || mv3);
	assign mv1          = s1_v && (!s2_v || mv2);
	assign sample.ready = !s1_v || mv1;
	assign accept       = sample.valid && sample.ready;

	assign hit_new = mv3 && (addr_s3 == addr_new);
	assign hit_s1  = mv3 && s1_v && (addr_s3 == addr_s1);
	assign up_s1   = fwd_v_q ? fwd_d_q : ram_rdata;

	// Products of neighbours that are already settled; the previous item's pixel is
	// folded into one coefficient and multiplied in the last stage.
	always_comb begin
		cl     = (COEF_W + 1)'(cfg.coef_left);
		cu     = (COEF_W + 1)'(cfg.coef_up);
		cul    = (COEF_W + 1)'(cfg.coef_upleft);
		ul_src = s3_v ? up_s3 : ul_q;
		cf_l   = '0;
		cf_u   = '0;
		term_u = '0;
		if (pos_s2.col_nz) begin
			cf_l   = cl;
			term_l = '0;
		end else begin
			term_l = mul_pix(EDGE_VALUE, cl);
		end
		if (!pos_s2.row_nz) begin
			term_u = mul_pix(EDGE_VALUE, cu);
		end else if (pos_s2.same_prev) begin
			cf_u = cu;
		end else begin
			term_u = mul_pix(up_s2, cu);
		end
		if (pos_s2.col_nz && pos_s2.row_nz) begin
			term_ul = mul_pix(ul_src, cul);
		end else begin
			term_ul = mul_pix(EDGE_VALUE, cul);
		end
		cf_c   = cf_l + cf_u;
		part_c = term_l + term_u + term_ul;
	end

	always_comb begin
		up_res = pos_s3.same_prev ? left_q : up_s3;
		sum    = part_s3 + mul_pix(left_q, cf_s3);
		adj    = sum + $signed({{(SUM_W - COEF_FRAC_BITS){1'b0}},
			{COEF_FRAC_BITS{sum[SUM_W-1]}}});
		pred   = adj >>> COEF_FRAC_BITS;
		enc    = VW'($signed({1'b0, pix_s3})) - VW'(pred);
		dec    = VW'(pred) + VW'(res_s3);
		flag   = 1'b0;
		if (mode_s3) begin
			res_val = '0;
			priority if (dec < VW'(0)) begin
				kept = '0;
				flag = 1'b1;
			end else if (dec > VW'(PIX_MAX)) begin
				kept = PIX_W'(PIX_MAX);
				flag = 1'b1;
			end else begin
				kept = dec[PIX_W-1:0];
			end
		end else begin
			kept = pix_s3;
			priority if (enc < VW'(RES_MIN)) begin
				res_val = RES_W'(RES_MIN);
				flag    = 1'b1;
			end else if (enc > VW'(RES_MAX)) begin
				res_val = RES_W'(RES_MAX);
				flag    = 1'b1;
			end else begin
				res_val = enc[RES_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v    <= 1'b0;
			s2_v    <= 1'b0;
			s3_v    <= 1'b0;
			out_v_q <= 1'b0;
			fwd_v_q <= 1'b0;
			left_q  <= EDGE_VALUE;
			ul_q    <= EDGE_VALUE;
		end else begin
			if (accept) begin
				s1_v <= 1'b1;
			end else if (mv1) begin
				s1_v <= 1'b0;
			end
			if (mv1) begin
				s2_v <= 1'b1;
			end else if (mv2) begin
				s2_v <= 1'b0;
			end
			if (mv2) begin
				s3_v <= 1'b1;
			end else if (mv3) begin
				s3_v <= 1'b0;
			end
			if (mv3) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
			priority if (accept) begin
				fwd_v_q <= hit_new;
			end else if (mv1) begin
				fwd_v_q <= 1'b0;
			end else if (hit_s1) begin
				fwd_v_q <= 1'b1;
			end
			if (mv3) begin
				left_q <= kept;
				ul_q   <= up_res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1  <= pos_new;
			addr_s1 <= addr_new;
			mode_s1 <= cfg.decode_mode;
			pix_s1  <= sample.pixel_in;
			res_s1  <= sample.residual_in;
		end
		if (accept ? hit_new : hit_s1) begin
			fwd_d_q <= kept;
		end
		if (mv1) begin
			pos_s2  <= pos_s1;
			addr_s2 <= addr_s1;
			mode_s2 <= mode_s1;
			pix_s2  <= pix_s1;
			res_s2  <= res_s1;
			up_s2   <= hit_s1 ? kept : up_s1;
		end
		if (mv2) begin
			pos_s3  <= pos_s2;
			addr_s3 <= addr_s2;
			mode_s3 <= mode_s2;
			pix_s3  <= pix_s2;
			res_s3  <= res_s2;
			up_s3   <= up_s2;
			part_s3 <= part_c;
			cf_s3   <= cf_c;
		end
		if (mv3) begin
			out_res_q  <= res_val;
			out_pix_q  <= kept;
			out_flag_q <= flag;
			out_end_q  <= pos_s3.last;
		end
	end

	assign result.valid        = out_v_q;
	assign result.residual_out = out_res_q;
	assign result.pixel_out    = out_pix_q;
	assign result.range_flag   = out_flag_q;
	assign result.frame_end    = out_end_q;

	a_fwd_in_s1: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_v_q |-> s1_v)
		else $error("forwarded line buffer data held with no item in the first stage");

	a_decode_res_zero: assert property (@(posedge clk) disable iff (!arst_n)
		mv3 && mode_s3 |=> result.residual_out == '0)
		else $error("decoded item carries a nonzero residual");

	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		mv3 |=> result.valid)
		else $error("finished item did not reach the output register");

	a_left_matches: assert property (@(posedge clk) disable iff (!arst_n)
		mv3 |=> left_q == result.pixel_out)
		else $error("left neighbour differs from the pixel just delivered");

endmodule

// ----- design/lppc_ram.sv -----
`timescale 1ns / 1ps

module lppc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- design/lppc_cfg.sv -----
`timescale 1ns / 1ps

module lppc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [lppc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lppc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output lppc_pkg::cfg_t                   cfg
);
	import lppc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decode_mode  <= 1'b0;
			cfg_q.coef_left    <= COEF_LEFT_RST;
			cfg_q.coef_up      <= COEF_ZERO_RST;
			cfg_q.coef_upleft  <= COEF_ZERO_RST;
			cfg_q.frame_width  <= FW_RST;
			cfg_q.frame_height <= FH_RST;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DECODE_MODE:  cfg_q.decode_mode  <= cfg_data[0];
				REG_COEF_LEFT:    cfg_q.coef_left    <= cfg_data;
				REG_COEF_UP:      cfg_q.coef_up      <= cfg_data;
				REG_COEF_UPLEFT:  cfg_q.coef_upleft  <= cfg_data;
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/lppc_pos.sv -----
`timescale 1ns / 1ps

module lppc_pos #(
	parameter int MAX_WIDTH = lppc_pkg::DEF_MAX_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  lppc_pkg::cfg_t               cfg,
	output logic [$clog2(MAX_WIDTH)-1:0] addr,
	output lppc_pkg::pos_t               pos
);
	import lppc_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = (AW + 1 > FW_W) ? AW + 1 : FW_W;

	logic [AW-1:0]   col_q;
	logic [FH_W-1:0] row_q;
	logic [AW-1:0]   prev_addr_q;

	logic [CW-1:0]   fw_x;
	logic [AW:0]     w_eff;
	logic [FH_W-1:0] h_eff;
	logic [AW:0]     col_x;
	logic [AW:0]     col_next;
	logic [FH_W:0]   row_next;
	logic            last_col;
	logic            last_row;

	always_comb begin
		fw_x = CW'(cfg.frame_width);
		priority if (fw_x == '0) begin
			w_eff = (AW + 1)'(1);
		end else if (fw_x > CW'(MAX_WIDTH)) begin
			w_eff = (AW + 1)'(MAX_WIDTH);
		end else begin
			w_eff = (AW + 1)'(fw_x);
		end
		h_eff    = (cfg.frame_height == '0) ? FH_W'(1) : cfg.frame_height;
		col_x    = {1'b0, col_q};
		addr     = (col_x >= w_eff) ? AW'(w_eff - (AW + 1)'(1)) : col_q;
		col_next = col_x + (AW + 1)'(1);
		row_next = {1'b0, row_q} + (FH_W + 1)'(1);
		last_col = (col_next >= w_eff);
		last_row = (row_next >= {1'b0, h_eff});

		pos.col_nz    = (col_q != '0);
		pos.row_nz    = (row_q != '0);
		pos.last      = last_col && last_row;
		pos.same_prev = (addr == prev_addr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			prev_addr_q <= '0;
		end else if (accept) begin
			prev_addr_q <= addr;
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_next[FH_W-1:0];
			end else begin
				col_q <= col_next[AW-1:0];
			end
		end
	end

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pos.last |=> col_q == '0 && row_q == '0)
		else $error("position did not return to the frame start after the last item");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !last_col |=> col_q == $past(col_q) + AW'(1) && row_q == $past(row_q))
		else $error("column did not advance by one inside a row");

endmodule

// ----- verif/lossless_predictive_pixel_codec_tb.sv -----
`timescale 1ns / 1ps

module lossless_predictive_pixel_codec_tb;
	import lppc_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE_TICKS = 10;
	localparam int ITEM_TARGET  = 950;

	typedef struct packed {
		logic signed [RES_W-1:0] residual;
		logic [PIX_W-1:0]        pixel;
		logic                    range_flag;
		logic                    frame_end;
	} codec_result_t;

	class codec_scoreboard;
		cfg_t             regs;
		logic [PIX_W-1:0] line_buf[DEF_MAX_WIDTH];
		bit               line_written[DEF_MAX_WIDTH];
		logic [PIX_W-1:0] left_pix;
		logic [PIX_W-1:0] upleft_pix;
		int unsigned      col_pos;
		int unsigned      row_pos;
		codec_result_t    pending[$];
		int               errors;

		function new();
			regs.decode_mode = 1'b0;
			regs.coef_left = COEF_LEFT_RST;
			regs.coef_up = COEF_ZERO_RST;
			regs.coef_upleft = COEF_ZERO_RST;
			regs.frame_width = FW_RST;
			regs.frame_height = FH_RST;
			foreach (line_buf[i]) line_buf[i] = '0;
			left_pix = EDGE_VALUE;
			upleft_pix = EDGE_VALUE;
			col_pos = 0;
			row_pos = 0;
			errors = 0;
		endfunction

		function int unsigned eff_width(logic [FW_W-1:0] fw);
			if (fw == 0) return 1;
			if (fw > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
			return fw;
		endfunction

		// A wider row must never make the next row read a column that was never stored.
		function bit width_safe(logic [FW_W-1:0] fw);
			if (row_pos == 0) return 1'b1;
			for (int i = 0; i < eff_width(fw); i++) begin
				if (!line_written[i]) return 1'b0;
			end
			return 1'b1;
		endfunction

		function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_DECODE_MODE:  regs.decode_mode = data[0];
				REG_COEF_LEFT:    regs.coef_left = data;
				REG_COEF_UP:      regs.coef_up = data;
				REG_COEF_UPLEFT:  regs.coef_upleft = data;
				REG_FRAME_WIDTH:  regs.frame_width = data[FW_W-1:0];
				REG_FRAME_HEIGHT: regs.frame_height = data[FH_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic [PIX_W-1:0] pix, logic signed [RES_W-1:0] res);
			int unsigned      w, h, col;
			longint           l, u, ul, acc, pred, val;
			logic [PIX_W-1:0] up_raw, kept;
			bit               last_col, last_row;
			codec_result_t    r;
			w = eff_width(regs.frame_width);
			h = (regs.frame_height == 0) ? 1 : regs.frame_height;
			col = (col_pos >= w) ? w - 1 : col_pos;
			up_raw = line_buf[col];
			l = (col_pos > 0) ? longint'(left_pix) : longint'(EDGE_VALUE);
			u = (row_pos > 0) ? longint'(up_raw) : longint'(EDGE_VALUE);
			ul = (col_pos > 0 && row_pos > 0) ? longint'(upleft_pix) : longint'(EDGE_VALUE);
			acc = l * longint'($signed(regs.coef_left)) + u * longint'($signed(regs.coef_up))
				+ ul * longint'($signed(regs.coef_upleft));
			if (acc < 0) begin
				pred = -((-acc) >>> DEF_COEF_FRAC_BITS);
			end else begin
				pred = acc >>> DEF_COEF_FRAC_BITS;
			end
			r.range_flag = 1'b0;
			if (regs.decode_mode) begin
				val = pred + longint'(res);
				if (val < 0) begin
					val = 0;
					r.range_flag = 1'b1;
				end
				if (val > 255) begin
					val = 255;
					r.range_flag = 1'b1;
				end
				kept = val[PIX_W-1:0];
				r.residual = '0;
			end else begin
				kept = pix;
				val = longint'(pix) - pred;
				if (val < -1024) begin
					val = -1024;
					r.range_flag = 1'b1;
				end
				if (val > 1023) begin
					val = 1023;
					r.range_flag = 1'b1;
				end
				r.residual = val[RES_W-1:0];
			end
			r.pixel = kept;
			upleft_pix = up_raw;
			line_buf[col] = kept;
			line_written[col] = 1'b1;
			left_pix = kept;
			last_col = (col_pos + 1 >= w);
			last_row = (row_pos + 1 >= h);
			r.frame_end = last_col && last_row;
			if (last_col) begin
				col_pos = 0;
				row_pos = last_row ? 0 : row_pos + 1;
			end else begin
				col_pos++;
			end
			pending.push_back(r);
		endfunction

		function void check_result(codec_result_t got);
			codec_result_t want;
			if (pending.size() == 0) begin
				$error("unexpected result item: residual_out %0d pixel_out %0d",
					got.residual, got.pixel);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.residual !== want.residual) begin
				$error("residual_out: expected %0d, got %0d", want.residual, got.residual);
				errors++;
			end
			if (got.pixel !== want.pixel) begin
				$error("pixel_out: expected %0d, got %0d", want.pixel, got.pixel);
				errors++;
			end
			if (got.range_flag !== want.range_flag) begin
				$error("range_flag: expected %0b, got %0b", want.range_flag, got.range_flag);
				errors++;
			end
			if (got.frame_end !== want.frame_end) begin
				$error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lppc_in_if  sample_ch();
	lppc_out_if result_ch();

	codec_scoreboard codec_sb = new();

	int               send_idle_pct = 37;
	int               recv_idle_pct = 37;
	int               items_sent = 0;
	int               stall_cycles = 0;
	logic [PIX_W-1:0] last_pix = 8'd128;

	always #1 clk = ~clk;

	lossless_predictive_pixel_codec u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready) begin
			codec_sb.check_result({result_ch.residual_out, result_ch.pixel_out,
				result_ch.range_flag, result_ch.frame_end});
		end
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		codec_sb.set_register(idx, data);
	endtask

	task automatic send_sample(logic [PIX_W-1:0] pix, logic signed [RES_W-1:0] res);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.pixel_in <= pix;
		sample_ch.residual_in <= res;
		do @(posedge clk); while (!(sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1));
		codec_sb.note_sample(pix, res);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		sample_ch.valid <= 1'b0;
		do @(negedge clk); while (codec_sb.pending.size() != 0);
	endtask

	function automatic logic [PIX_W-1:0] next_pixel();
		int pick, d, v;
		pick = $urandom_range(9);
		d = $urandom_range(16);
		if (pick < 3) begin
			v = $urandom_range(255);
		end else begin
			v = int'(last_pix) + d - 8;
			if (v < 0) v = 0;
			if (v > 255) v = 255;
		end
		last_pix = v[PIX_W-1:0];
		return v[PIX_W-1:0];
	endfunction

	function automatic logic signed [RES_W-1:0] next_residual();
		int          pick, d;
		logic [31:0] raw;
		pick = $urandom_range(9);
		raw = $urandom;
		d = $urandom_range(32);
		d = d - 16;
		case (pick)
			0:       return raw[RES_W-1:0];
			1:       return raw[0] ? 11'sh3ff : 11'sh400;
			default: return d[RES_W-1:0];
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] pick_coef();
		int          pick;
		logic [31:0] raw;
		pick = $urandom_range(9);
		raw = $urandom;
		case (pick)
			0:       return raw[0] ? 16'h7fff : 16'h8000;
			1, 2:    return raw[15:0];
			3:       return 16'h0000;
			4:       return 16'h0800;
			5:       return 16'hf000;
			default: return 16'h1000 + {8'h00, raw[7:0]} - 16'h0080;
		endcase
	endfunction

	task automatic random_setup();
		logic [31:0]     raw;
		int              pick;
		logic [FW_W-1:0] fw;
		raw = $urandom;
		if (raw[8]) write_reg(REG_DECODE_MODE, raw[31:16]);
		if (raw[9]) write_reg(REG_COEF_LEFT, pick_coef());
		if (raw[10]) write_reg(REG_COEF_UP, pick_coef());
		if (raw[11]) write_reg(REG_COEF_UPLEFT, pick_coef());
		if (raw[12]) begin
			pick = $urandom_range(19);
			if (pick == 0) begin
				fw = FW_W'(11'd1024 + $urandom_range(1023));
			end else if (pick == 1) begin
				fw = '0;
			end else if (pick < 5) begin
				fw = FW_W'($urandom_range(40, 1));
			end else begin
				fw = FW_W'($urandom_range(12, 1));
			end
			if (codec_sb.width_safe(fw)) write_reg(REG_FRAME_WIDTH, {raw[4:0], fw});
		end
		if (raw[13]) begin
			pick = $urandom_range(19);
			if (pick == 0) begin
				write_reg(REG_FRAME_HEIGHT, 16'hffff);
			end else if (pick == 1) begin
				write_reg(REG_FRAME_HEIGHT, 16'h0000);
			end else begin
				write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(6, 1)));
			end
		end
	endtask

	initial begin
		int phase;
		int n;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_DECODE_MODE;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.pixel_in = '0;
		sample_ch.residual_in = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Most negative weights push every residual to the positive limit.
		write_reg(REG_FRAME_WIDTH, 16'd4);
		write_reg(REG_FRAME_HEIGHT, 16'd3);
		write_reg(REG_COEF_LEFT, 16'h8000);
		write_reg(REG_COEF_UP, 16'h8000);
		write_reg(REG_COEF_UPLEFT, 16'h8000);
		send_sample(8'd0, 11'sh400);
		send_sample(8'd255, 11'sh3ff);
		send_sample(8'd0, 11'sh000);
		send_sample(8'd255, 11'sh7ff);
		drain();
		write_reg(REG_COEF_LEFT, 16'h7fff);
		write_reg(REG_COEF_UP, 16'h7fff);
		write_reg(REG_COEF_UPLEFT, 16'h7fff);
		send_sample(8'd255, 11'sh000);
		send_sample(8'd0, 11'sh000);
		send_sample(8'd255, 11'sh000);
		send_sample(8'd128, 11'sh000);
		drain();
		write_reg(REG_DECODE_MODE, 16'd1);
		send_sample(8'hff, 11'sh400);
		send_sample(8'h00, 11'sh3ff);
		send_sample(8'hff, 11'sh000);
		send_sample(8'h00, 11'sh7ff);
		drain();
		write_reg(REG_COEF_LEFT, 16'h1000);
		write_reg(REG_COEF_UP, 16'h0000);
		write_reg(REG_COEF_UPLEFT, 16'h0000);
		write_reg(REG_FRAME_WIDTH, 16'd0);
		write_reg(REG_FRAME_HEIGHT, 16'd0);
		send_sample(8'd0, 11'sd5);
		send_sample(8'd0, -11'sd7);
		send_sample(8'd0, 11'sh3ff);
		drain();
		write_reg(REG_DECODE_MODE, 16'd0);
		write_reg(REG_FRAME_WIDTH, 16'h07ff);
		write_reg(REG_FRAME_HEIGHT, 16'd2);
		send_sample(8'd10, 11'sh000);
		send_sample(8'd20, 11'sh000);
		send_sample(8'd30, 11'sh000);
		send_sample(8'd40, 11'sh000);
		send_sample(8'd50, 11'sh000);
		drain();
		// The column now lies past the narrower row, so the next item ends the row.
		write_reg(REG_FRAME_WIDTH, 16'd3);
		send_sample(8'd60, 11'sh000);
		send_sample(8'd70, 11'sh000);
		drain();
		write_reg(REG_FRAME_HEIGHT, 16'd1);
		write_reg(REG_DECODE_MODE, 16'd1);
		send_sample(8'd0, 11'sd3);
		send_sample(8'd0, -11'sd2);

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			drain();
			random_setup();
			if (phase >= 4 && phase < 9) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else begin
				send_idle_pct = 37;
				recv_idle_pct = 37;
			end
			if (codec_sb.eff_width(codec_sb.regs.frame_width) > 64) begin
				n = $urandom_range(40, 10);
			end else begin
				n = $urandom_range(80, 10);
			end
			repeat (n) send_sample(next_pixel(), next_residual());
			phase++;
		end

		drain();
		repeat (SETTLE_TICKS) @(negedge clk);
		if (codec_sb.pending.size() != 0) begin
			$error("%0d expected result items never arrived", codec_sb.pending.size());
			codec_sb.errors++;
		end
		if (codec_sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
